// ===== rtl/pia_pkg.sv =====
package pia_pkg;

    localparam int CAPACITY   = 16;
    localparam int ITEM_WIDTH = 32;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 5;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W   = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

    typedef logic [ITEM_WIDTH-1:0] t_item;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ   = 3'd0,
        FN_INSERT = 3'd1,
        FN_ERASE  = 3'd2,
        FN_CLEAR  = 3'd3,
        FN_PUSH   = 3'd4,
        FN_POP    = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

endpackage

// ===== rtl/pia_if.sv =====
interface pia_req_if;
    import pia_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] item_value;

    modport source (output valid, output func, output position, output item_value,
                    input ready);
    modport sink   (input valid, input func, input position, input item_value,
                    output ready);
endinterface

interface pia_rsp_if;
    import pia_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    output ready);
endinterface

// ===== rtl/pia_cell.sv =====
module pia_cell (
    input  logic                i_clk,
    input  pia_pkg::t_cell_ctl  i_ctl,
    input  pia_pkg::t_item      i_left,
    input  pia_pkg::t_item      i_right,
    input  pia_pkg::t_item      i_word,
    output pia_pkg::t_item      o_value
);
    import pia_pkg::*;

    t_item r_value;
    t_item n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_word;
        end else if (i_ctl.shift_up) begin
            n_value = i_left;
        end else if (i_ctl.shift_down) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/positional_insert_erase_array.sv =====
// A registered result appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle, stalled while a result waits untaken;
// every cell shifts, loads or holds in the same cycle; output frees when taken.
// Reset: synchronous active-low reset empties the array and drops the output
// valid; stored words are not cleared and stay unreachable until rewritten.
module positional_insert_erase_array (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pia_req_if.sink   i_req,
    pia_rsp_if.source o_rsp
);
    import pia_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [WORD_W-1:0] r_read_value;
    logic [WORD_W-1:0] n_read_value;

    logic              w_accept;
    logic              w_do_ins;
    logic              w_do_ers;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_ins_pos;
    logic [CMP_W-1:0]  w_cnt;
    t_item             w_word;
    t_item             w_cell_value [CAPACITY];
    t_cell_ctl         w_cell_ctl   [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_pos       = CMP_W'(i_req.position);
    assign w_cnt       = CMP_W'(r_count);
    assign w_word      = ITEM_WIDTH'(i_req.item_value);

    always_comb begin
        n_count      = r_count;
        n_status     = ST_RANGE;
        n_read_value = '0;
        w_do_ins     = 1'b0;
        w_do_ers     = 1'b0;
        w_ins_pos    = w_pos;
        case (t_func'(i_req.func))
            FN_READ: begin
                if (w_pos < w_cnt) begin
                    n_status     = ST_OK;
                    n_read_value = WORD_W'(w_cell_value[w_pos[IDX_W-1:0]]);
                end
            end
            FN_INSERT, FN_PUSH: begin
                if (t_func'(i_req.func) == FN_PUSH) begin
                    w_ins_pos = w_cnt;
                end
                if (w_ins_pos > w_cnt) begin
                    n_status = ST_RANGE;
                end else if (w_cnt == CMP_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    w_do_ins = w_accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            FN_ERASE: begin
                if (w_pos < w_cnt) begin
                    n_status = ST_OK;
                    w_do_ers = w_accept;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            FN_CLEAR: begin
                n_status = ST_OK;
                n_count  = '0;
            end
            FN_POP: begin
                if (r_count != '0) begin
                    n_status = ST_OK;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_item w_left;
        t_item w_right;

        if (g == 0) begin : g_first
            assign w_left = w_word;
        end else begin : g_inner_l
            assign w_left = w_cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_value[g];
        end else begin : g_inner_r
            assign w_right = w_cell_value[g+1];
        end

        assign w_cell_ctl[g].load       = w_do_ins && (CMP_W'(g) == w_ins_pos);
        assign w_cell_ctl[g].shift_up   = w_do_ins && (CMP_W'(g) > w_ins_pos);
        assign w_cell_ctl[g].shift_down = w_do_ers && (CMP_W'(g) >= w_pos);

        pia_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_cell_ctl[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_word  (w_word),
            .o_value (w_cell_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.count      = r_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (CMP_W'(r_count) == CMP_W'(CAPACITY)))
        else $error("Full status reported while the array is not full.");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_read_value == '0))
        else $error("Nonzero read value on a refused request.");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("Accepted request beat produced no result beat.");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("Entry count changed without an accepted request.");
`endif

endmodule
